### sv/wbs_pkg.sv
// Shared types and constants for the white blob steering unit.
`timescale 1ns / 1ps
`default_nettype none
package wbs_pkg;

  // Pixel transaction on the input channel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } in_item_t;

  // Steering result transaction, one per frame
  typedef struct packed {
    logic               target_found;
    logic        [11:0] blob_centre;
    logic        [11:0] blob_width;
    logic signed [19:0] linear_cmd;
    logic signed [19:0] angular_cmd;
  } out_item_t;

  // Register file contents, plus the precomputed third of the row
  typedef struct packed {
    logic [11:0] image_width;
    logic [7:0]  white_level;
    logic [19:0] lin_gain;
    logic [19:0] ang_gain;
    logic [11:0] width_reference;
    logic [11:0] centre_reference;
    logic [10:0] third;
  } cfg_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [2:0] REG_WHITE_LEVEL      = 3'd1;
  localparam logic [2:0] REG_LIN_GAIN         = 3'd2;
  localparam logic [2:0] REG_ANG_GAIN         = 3'd3;
  localparam logic [2:0] REG_WIDTH_REFERENCE  = 3'd4;
  localparam logic [2:0] REG_CENTRE_REFERENCE = 3'd5;

  // Reset values
  localparam logic [11:0] RST_IMAGE_WIDTH      = 12'd640;
  localparam logic [7:0]  RST_WHITE_LEVEL      = 8'd255;
  localparam logic [19:0] RST_LIN_GAIN         = 20'd13981;
  localparam logic [19:0] RST_ANG_GAIN         = 20'd65878;
  localparam logic [11:0] RST_WIDTH_REFERENCE  = 12'd600;
  localparam logic [11:0] RST_CENTRE_REFERENCE = 12'd400;
  localparam logic [10:0] RST_THIRD            = 11'd213;

  // floor(w / 3) = (w * 2731) >> 13, exact for w below 8192
  localparam logic [11:0] THIRD_RECIP = 12'd2731;
  localparam int          THIRD_SHIFT = 13;

endpackage
`default_nettype wire

### sv/wbs_regs.sv
// APB register file for the steering unit configuration.
`timescale 1ns / 1ps
`default_nettype none
module wbs_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output wbs_pkg::cfg_t     cfg
);

  wbs_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;
  logic [23:0]   third_prod;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // third of the row, by reciprocal multiply on the incoming width
  assign third_prod = 24'(pwdata[11:0]) * 24'(wbs_pkg::THIRD_RECIP);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= wbs_pkg::RST_IMAGE_WIDTH;
      cfg_r.white_level      <= wbs_pkg::RST_WHITE_LEVEL;
      cfg_r.lin_gain         <= wbs_pkg::RST_LIN_GAIN;
      cfg_r.ang_gain         <= wbs_pkg::RST_ANG_GAIN;
      cfg_r.width_reference  <= wbs_pkg::RST_WIDTH_REFERENCE;
      cfg_r.centre_reference <= wbs_pkg::RST_CENTRE_REFERENCE;
      cfg_r.third            <= wbs_pkg::RST_THIRD;
    end else if (wr_en) begin
      unique case (reg_idx)
        wbs_pkg::REG_IMAGE_WIDTH: begin
          cfg_r.image_width <= pwdata[11:0];
          cfg_r.third       <= third_prod[23:wbs_pkg::THIRD_SHIFT];
        end
        wbs_pkg::REG_WHITE_LEVEL:      cfg_r.white_level      <= pwdata[7:0];
        wbs_pkg::REG_LIN_GAIN:         cfg_r.lin_gain         <= pwdata[19:0];
        wbs_pkg::REG_ANG_GAIN:         cfg_r.ang_gain         <= pwdata[19:0];
        wbs_pkg::REG_WIDTH_REFERENCE:  cfg_r.width_reference  <= pwdata[11:0];
        wbs_pkg::REG_CENTRE_REFERENCE: cfg_r.centre_reference <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      wbs_pkg::REG_IMAGE_WIDTH:      prdata = 32'(cfg_r.image_width);
      wbs_pkg::REG_WHITE_LEVEL:      prdata = 32'(cfg_r.white_level);
      wbs_pkg::REG_LIN_GAIN:         prdata = 32'(cfg_r.lin_gain);
      wbs_pkg::REG_ANG_GAIN:         prdata = 32'(cfg_r.ang_gain);
      wbs_pkg::REG_WIDTH_REFERENCE:  prdata = 32'(cfg_r.width_reference);
      wbs_pkg::REG_CENTRE_REFERENCE: prdata = 32'(cfg_r.centre_reference);
      default:                       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### sv/wbs_extent.sv
// Column counter, white pixel detect and extent tracking with frame snapshot.
`timescale 1ns / 1ps
`default_nettype none
module wbs_extent #(
  parameter int COLUMN_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire wbs_pkg::cfg_t          cfg,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire wbs_pkg::in_item_t      in_data,
  output logic                        snap_vld,
  input  wire logic                   snap_take,
  output logic                        snap_seen,
  output logic [COLUMN_BITS-1:0]      snap_left,
  output logic [COLUMN_BITS-1:0]      snap_right
);

  localparam int CW    = COLUMN_BITS;
  localparam int CMP_W = (CW >= 12) ? CW + 1 : 13;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] right_r, right_nxt;
  logic          seen_r, seen_nxt;
  logic          snap_vld_r, snap_seen_r;
  logic [CW-1:0] snap_left_r, snap_right_r;
  logic [CW:0]   col_inc;
  logic          accept, white, wrap;

  // one frame result may wait in the snapshot register
  assign in_stall = snap_vld_r & ~snap_take;
  assign accept   = in_valid & ~in_stall;

  assign white = (in_data.red == cfg.white_level) && (in_data.green == cfg.white_level)
              && (in_data.blue == cfg.white_level);

  // column wrap
  assign col_inc = {1'b0, col_r} + {{CW{1'b0}}, 1'b1};
  assign wrap    = CMP_W'(col_inc) >= CMP_W'(cfg.image_width);
  assign col_nxt = wrap ? '0 : col_inc[CW-1:0];

  // extent including the current pixel
  always_comb begin
    seen_nxt  = seen_r | white;
    left_nxt  = (white && (col_r < left_r))  ? col_r : left_r;
    right_nxt = (white && (col_r > right_r)) ? col_r : right_r;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      left_r  <= '1;
      right_r <= '0;
      seen_r  <= 1'b0;
    end else if (accept) begin
      if (in_data.frame_end) begin
        col_r   <= '0;
        left_r  <= '1;
        right_r <= '0;
        seen_r  <= 1'b0;
      end else begin
        col_r   <= col_nxt;
        left_r  <= left_nxt;
        right_r <= right_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  // snapshot handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
    end else if (accept && in_data.frame_end) begin
      snap_vld_r <= 1'b1;
    end else if (snap_take) begin
      snap_vld_r <= 1'b0;
    end
  end

  // snapshot payload
  always_ff @(posedge clk) begin
    if (accept && in_data.frame_end) begin
      snap_seen_r  <= seen_nxt;
      snap_left_r  <= left_nxt;
      snap_right_r <= right_nxt;
    end
  end

  assign snap_vld   = snap_vld_r;
  assign snap_seen  = snap_seen_r;
  assign snap_left  = snap_left_r;
  assign snap_right = snap_right_r;

endmodule
`default_nettype wire

### sv/wbs_cmd.sv
// Centre, width and steering command arithmetic with the result register.
`timescale 1ns / 1ps
`default_nettype none
module wbs_cmd #(
  parameter int COLUMN_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire wbs_pkg::cfg_t          cfg,
  input  wire logic                   snap_vld,
  output logic                        snap_take,
  input  wire logic                   snap_seen,
  input  wire logic [COLUMN_BITS-1:0] snap_left,
  input  wire logic [COLUMN_BITS-1:0] snap_right,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output wbs_pkg::out_item_t          out_data
);

  localparam int CW     = COLUMN_BITS;
  localparam int EXT_W  = (CW > 12) ? CW : 12;
  localparam int DIFF_W = EXT_W + 1;
  localparam int PROD_W = DIFF_W + 21;
  localparam int Q_W    = PROD_W - 12;
  localparam logic signed [PROD_W-1:0] RND     = PROD_W'(2048);
  localparam logic signed [Q_W-1:0]    SAT_MAX = Q_W'(524287);
  localparam logic signed [Q_W-1:0]    SAT_MIN = -(Q_W'(524288));

  logic                      out_valid_r;
  wbs_pkg::out_item_t        out_data_r, res;
  logic [CW:0]               sum;
  logic [EXT_W-1:0]          centre, width, third_ext;
  logic                      in_mid;
  logic signed [DIFF_W-1:0]  diff_lin, diff_ang, diff_sel;
  logic [19:0]               gain_sel;
  logic signed [PROD_W-1:0]  prod, prod_rnd;
  logic signed [Q_W-1:0]     q;
  logic signed [19:0]        cmd_sat;

  assign snap_take = snap_vld & (~out_valid_r | ~out_stall);

  // blob geometry
  assign sum       = {1'b0, snap_left} + {1'b0, snap_right};
  assign centre    = EXT_W'(sum[CW:1]);
  assign width     = EXT_W'(snap_right - snap_left);
  assign third_ext = EXT_W'(cfg.third);
  assign in_mid    = (centre > third_ext) && (centre < EXT_W'({cfg.third, 1'b0}));

  // error terms and the single shared multiplier
  assign diff_lin = $signed({1'b0, EXT_W'(cfg.width_reference)}) - $signed({1'b0, width});
  assign diff_ang = $signed({1'b0, EXT_W'(cfg.centre_reference)}) - $signed({1'b0, centre});
  assign diff_sel = in_mid ? diff_lin : diff_ang;
  assign gain_sel = in_mid ? cfg.lin_gain : cfg.ang_gain;
  // full-width signed product, operands sign-extended to the product width
  assign prod     = $signed({1'b0, gain_sel}) * diff_sel;

  // Q.24 to Q.12, round half up, saturate
  assign prod_rnd = prod + RND;
  assign q        = Q_W'(prod_rnd >>> 12);
  always_comb begin
    if (q > SAT_MAX) begin
      cmd_sat = 20'sd524287;
    end else if (q < SAT_MIN) begin
      cmd_sat = -20'sd524288;
    end else begin
      cmd_sat = q[19:0];
    end
  end

  // result fields; all zero when nothing was found
  always_comb begin
    res.target_found = snap_seen;
    if (snap_seen) begin
      res.blob_centre = centre[11:0];
      res.blob_width  = width[11:0];
      res.linear_cmd  = in_mid ? cmd_sat : '0;
      res.angular_cmd = in_mid ? '0 : cmd_sat;
    end else begin
      res.blob_centre = '0;
      res.blob_width  = '0;
      res.linear_cmd  = '0;
      res.angular_cmd = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### sv/white_blob_steering_unit.sv
// Top level of the white blob steering unit.
//
//   Channel  Ports                                   Moves
//   in       in_valid / in_stall / in_data           one RGB pixel, raster order
//   out      out_valid / out_stall / out_data        one steering result per frame
//   cfg      psel penable pwrite paddr pwdata ...    six configuration registers
//
// One pixel transaction per clock while in_stall is low. A pixel updates the
// column and extent registers at the edge it is accepted; a frame_end pixel
// also loads the snapshot register, and then, once the result register is free
// or drains, the command arithmetic (one 21 x 13 multiply) loads the result
// register. Reset is synchronous and needs no clearing pass. in_stall is
// raised only while a snapshot is held and the result register is stalled.
`timescale 1ns / 1ps
`default_nettype none
module white_blob_steering_unit #(
  parameter int COLUMN_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wbs_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wbs_pkg::out_item_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  wbs_pkg::cfg_t          cfg;
  logic                   snap_vld, snap_take, snap_seen;
  logic [COLUMN_BITS-1:0] snap_left, snap_right;

  // configuration registers
  wbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-pixel extent tracking
  wbs_extent #(.COLUMN_BITS(COLUMN_BITS)) u_extent (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .snap_vld   (snap_vld),
    .snap_take  (snap_take),
    .snap_seen  (snap_seen),
    .snap_left  (snap_left),
    .snap_right (snap_right)
  );

  // per-frame command arithmetic
  wbs_cmd #(.COLUMN_BITS(COLUMN_BITS)) u_cmd (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .snap_vld   (snap_vld),
    .snap_take  (snap_take),
    .snap_seen  (snap_seen),
    .snap_left  (snap_left),
    .snap_right (snap_right),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

### bench/white_blob_steering_unit_tb.sv
// Self-checking bench for the white blob steering unit: directed and random pixel frames.
`timescale 1ns / 1ps
module white_blob_steering_unit_tb;

  // Unmapped register slots, writes there must leave every register alone
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam int RANDOM_PIXELS = 1850;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 36;

  localparam logic [19:0] GAIN_MAX   = 20'hFFFFF;
  localparam logic [11:0] COL_MAX    = 12'hFFF;
  localparam longint      CMD_TOP    = 524287;
  localparam longint      CMD_BOTTOM = -524288;

  // Pixel flavours for the stimulus generator
  localparam int PIX_MIXED = 0;
  localparam int PIX_WHITE = 1;
  localparam int PIX_PLAIN = 2;

  localparam wbs_pkg::out_item_t NO_BLOB        = '0;
  localparam wbs_pkg::out_item_t TURN_SATURATED =
    '{1'b1, 12'd0, 12'd0, 20'sd0, 20'sd524287};

  typedef enum {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [31:0]        val;
    wbs_pkg::in_item_t  px;
    bit                 known;
    wbs_pkg::out_item_t res;
  } stim_row_t;

  typedef struct {
    bit                 known;
    wbs_pkg::out_item_t res;
  } fixed_answer_t;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  wbs_pkg::in_item_t  in_data  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wbs_pkg::out_item_t out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [4:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  white_blob_steering_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Register shadow
  logic [11:0] row_len     = wbs_pkg::RST_IMAGE_WIDTH;
  logic [7:0]  white_val   = wbs_pkg::RST_WHITE_LEVEL;
  logic [19:0] fwd_gain    = wbs_pkg::RST_LIN_GAIN;
  logic [19:0] turn_gain   = wbs_pkg::RST_ANG_GAIN;
  logic [11:0] width_goal  = wbs_pkg::RST_WIDTH_REFERENCE;
  logic [11:0] centre_goal = wbs_pkg::RST_CENTRE_REFERENCE;

  // Frame tracking state
  logic [11:0] col_pos    = '0;
  logic [11:0] span_lo    = COL_MAX;
  logic [11:0] span_hi    = '0;
  logic        blob_seen  = 1'b0;

  wbs_pkg::out_item_t pending_cmds[$];
  fixed_answer_t      fixed_answers[$];
  stim_row_t          dir_rows[$];

  int mismatches  = 0;
  int cycles      = 0;
  int random_sent = 0;
  bit calm        = 1'b0;
  bit bus_busy    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gain (Q0.24) times a signed difference, rounded half up to Q7.12, saturated
  function automatic logic [19:0] steer_cmd(logic [19:0] gain, longint diff);
    longint prod;
    prod = longint'(gain) * diff + 2048;
    prod = prod >>> 12;
    if (prod > CMD_TOP) prod = CMD_TOP;
    if (prod < CMD_BOTTOM) prod = CMD_BOTTOM;
    return prod[19:0];
  endfunction

  // Advance the frame state by one pixel; returns 1 with the steering result on frame end
  function automatic bit track_pixel(wbs_pkg::in_item_t px, output wbs_pkg::out_item_t res);
    int centre;
    int span;
    int third;
    res = '0;
    if (px.red == white_val && px.green == white_val && px.blue == white_val) begin
      blob_seen = 1'b1;
      if (col_pos < span_lo) span_lo = col_pos;
      if (col_pos > span_hi) span_hi = col_pos;
    end
    if (int'(col_pos) + 1 >= int'(row_len)) col_pos = '0;
    else col_pos = col_pos + 12'd1;
    if (!px.frame_end) return 1'b0;
    if (blob_seen) begin
      centre = (int'(span_lo) + int'(span_hi)) / 2;
      span   = int'(span_hi) - int'(span_lo);
      third  = int'(row_len) / 3;
      res.target_found = 1'b1;
      res.blob_centre  = 12'(centre);
      res.blob_width   = 12'(span);
      // middle third drives forward on width, else turn on centre
      if (centre > third && centre < 2 * third)
        res.linear_cmd = steer_cmd(fwd_gain, longint'(width_goal) - longint'(span));
      else
        res.angular_cmd = steer_cmd(turn_gain, longint'(centre_goal) - longint'(centre));
    end
    col_pos   = '0;
    span_lo   = COL_MAX;
    span_hi   = '0;
    blob_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(wbs_pkg::out_item_t got);
    wbs_pkg::out_item_t want;
    if (pending_cmds.size() == 0) begin
      note_mismatch("result transaction with nothing outstanding");
      return;
    end
    want = pending_cmds.pop_front();
    if (got.target_found !== want.target_found)
      note_mismatch($sformatf("target_found %0d, want %0d", got.target_found,
                              want.target_found));
    if (got.blob_centre !== want.blob_centre)
      note_mismatch($sformatf("blob_centre %0d, want %0d", got.blob_centre, want.blob_centre));
    if (got.blob_width !== want.blob_width)
      note_mismatch($sformatf("blob_width %0d, want %0d", got.blob_width, want.blob_width));
    if (got.linear_cmd !== want.linear_cmd)
      note_mismatch($sformatf("linear_cmd %0d, want %0d", got.linear_cmd, want.linear_cmd));
    if (got.angular_cmd !== want.angular_cmd)
      note_mismatch($sformatf("angular_cmd %0d, want %0d", got.angular_cmd,
                              want.angular_cmd));
  endtask

  // Watch both channels; predictions are pushed before results are checked
  always @(posedge clk) begin
    wbs_pkg::out_item_t res;
    fixed_answer_t      tag;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tag = fixed_answers.pop_front();
        if (track_pixel(in_data, res)) pending_cmds.push_back(tag.known ? tag.res : res);
      end
      if (out_valid && !out_stall) check_result(out_data);
    end
  end

  // Result side back-pressure
  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Setup then access phase; the bus is left selected so writes can run back to back
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    bus_busy = 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      wbs_pkg::REG_IMAGE_WIDTH:      row_len     = val[11:0];
      wbs_pkg::REG_WHITE_LEVEL:      white_val   = val[7:0];
      wbs_pkg::REG_LIN_GAIN:         fwd_gain    = val[19:0];
      wbs_pkg::REG_ANG_GAIN:         turn_gain   = val[19:0];
      wbs_pkg::REG_WIDTH_REFERENCE:  width_goal  = val[11:0];
      wbs_pkg::REG_CENTRE_REFERENCE: centre_goal = val[11:0];
      default: ;
    endcase
  endtask

  task automatic release_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bus_busy = 1'b0;
  endtask

  // Wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_pixel(wbs_pkg::in_item_t px, bit known, wbs_pkg::out_item_t res);
    if (bus_busy) release_bus();
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    fixed_answers.push_back('{known, res});
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mixed pixels: white, one bit off white, or anything at all; all white or never white in the other modes
  function automatic wbs_pkg::in_item_t make_pixel(int mode, bit last);
    wbs_pkg::in_item_t px;
    int                pick;
    logic [7:0]        flip;
    pick = (mode == PIX_MIXED) ? $urandom_range(0, 9) : 0;
    px.red       = 8'($urandom);
    px.green     = 8'($urandom);
    px.blue      = 8'($urandom);
    px.frame_end = last;
    if (mode == PIX_WHITE || (mode == PIX_MIXED && pick < 4)) begin
      px.red   = white_val;
      px.green = white_val;
      px.blue  = white_val;
    end else if (mode == PIX_MIXED && pick < 6) begin
      px.red   = white_val;
      px.green = white_val;
      px.blue  = white_val;
      flip     = 8'd1 << $urandom_range(0, 7);
      case ($urandom_range(0, 2))
        0: px.red = px.red ^ flip;
        1: px.green = px.green ^ flip;
        default: px.blue = px.blue ^ flip;
      endcase
    end else if (mode == PIX_PLAIN && px.red == white_val && px.green == white_val
                 && px.blue == white_val) begin
      px.blue = ~white_val;
    end
    return px;
  endfunction

  // Mostly small values, sometimes the extremes or anywhere in range
  function automatic logic [31:0] spread_value(int unsigned top, int unsigned usual);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return top;
      2, 3, 4: return $urandom_range(0, top);
      default: return $urandom_range(0, usual);
    endcase
  endfunction

  function automatic stim_row_t pix_row(int r, int g, int b, int last);
    stim_row_t row;
    row       = '{ROW_PIXEL, 3'd0, 32'd0, '0, 1'b0, '0};
    row.px    = '{8'(r), 8'(g), 8'(b), 1'(last)};
    return row;
  endfunction

  function automatic stim_row_t known_row(int r, int g, int b, int last,
                                          wbs_pkg::out_item_t res);
    stim_row_t row;
    row       = pix_row(r, g, b, last);
    row.known = 1'b1;
    row.res   = res;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] idx, logic [31:0] val);
    return '{ROW_REG, idx, val, '0, 1'b0, '0};
  endfunction

  // New register settings, then a handful of frames of random pixels
  task automatic random_phase();
    int len;
    int mode;
    settle();
    write_reg(wbs_pkg::REG_IMAGE_WIDTH, spread_value(4095, 48));
    write_reg(wbs_pkg::REG_WHITE_LEVEL, spread_value(255, 255));
    write_reg(wbs_pkg::REG_LIN_GAIN, spread_value(GAIN_MAX, 70000));
    write_reg(wbs_pkg::REG_ANG_GAIN, spread_value(GAIN_MAX, 70000));
    write_reg(wbs_pkg::REG_WIDTH_REFERENCE, spread_value(4095, 64));
    write_reg(wbs_pkg::REG_CENTRE_REFERENCE, spread_value(4095, 64));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    repeat ($urandom_range(2, 6)) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 250) : $urandom_range(1, 60);
      // now and then a frame with no white at all, or nothing but white
      case ($urandom_range(0, 9))
        0: mode = PIX_PLAIN;
        1: mode = PIX_WHITE;
        default: mode = PIX_MIXED;
      endcase
      for (int i = 0; i < len; i++) begin
        send_pixel(make_pixel(mode, i == len - 1), 1'b0, '0);
        random_sent++;
        // a stretch with neither side idling
        calm = (random_sent >= 700 && random_sent < 1000);
      end
    end
  endtask

  initial begin
    // empty frame straight out of reset
    dir_rows.push_back(known_row(0, 0, 0, 1, NO_BLOB));
    // one channel off white in each position
    dir_rows.push_back(pix_row(255, 255, 254, 0));
    dir_rows.push_back(pix_row(254, 255, 255, 0));
    dir_rows.push_back(known_row(255, 254, 255, 1, NO_BLOB));
    // lone white pixel, fresh frame at column zero
    dir_rows.push_back(pix_row(255, 255, 255, 1));
    // six-column row, blob in the middle third, maximum gain, negative width error
    dir_rows.push_back(reg_row(wbs_pkg::REG_IMAGE_WIDTH, 6));
    dir_rows.push_back(reg_row(wbs_pkg::REG_LIN_GAIN, GAIN_MAX));
    dir_rows.push_back(reg_row(wbs_pkg::REG_WIDTH_REFERENCE, 0));
    dir_rows.push_back(pix_row(0, 0, 0, 0));
    dir_rows.push_back(pix_row(0, 0, 0, 0));
    dir_rows.push_back(pix_row(0, 0, 0, 0));
    dir_rows.push_back(pix_row(255, 255, 255, 0));
    dir_rows.push_back(pix_row(255, 255, 255, 1));
    // row of one column: every pixel stays at column zero, turn saturates high
    dir_rows.push_back(reg_row(wbs_pkg::REG_IMAGE_WIDTH, 1));
    dir_rows.push_back(reg_row(wbs_pkg::REG_ANG_GAIN, GAIN_MAX));
    dir_rows.push_back(reg_row(wbs_pkg::REG_CENTRE_REFERENCE, COL_MAX));
    dir_rows.push_back(pix_row(255, 255, 255, 0));
    dir_rows.push_back(known_row(255, 255, 255, 1, TURN_SATURATED));
    // unmapped slots are ignored
    dir_rows.push_back(reg_row(REG_SPARE_6, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(REG_SPARE_7, 32'h0));
    // black counts as white, widest row
    dir_rows.push_back(reg_row(wbs_pkg::REG_WHITE_LEVEL, 0));
    dir_rows.push_back(reg_row(wbs_pkg::REG_IMAGE_WIDTH, COL_MAX));
    dir_rows.push_back(known_row(0, 0, 0, 1, TURN_SATURATED));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!bus_busy) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].res);
      end
    end

    while (random_sent < RANDOM_PIXELS) random_phase();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
